// File: hw/rtl/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, opcodes, event codes
// and the result struct shared by the parser, the output stage and the top level.
// No dependencies.
package wsd_pkg;

  // Frame opcodes of interest
  localparam logic [3:0] OP_DATA_MAX = 4'd2;   // continuation, text, binary
  localparam logic [3:0] OP_CLOSE    = 4'd8;
  localparam logic [3:0] OP_PING     = 4'd9;
  localparam logic [3:0] OP_PONG     = 4'd10;

  // Length code that announces a 16-bit extended length
  localparam logic [6:0] LEN_EXT16   = 7'd126;

  // Event kinds on the result channel
  typedef enum logic [1:0] {
    EV_DATA  = 2'd0,
    EV_PING  = 2'd1,
    EV_CLOSE = 2'd2,
    EV_BADOP = 2'd3
  } wsd_event_t;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HDR0,     // first header byte: FIN and opcode
    PH_HDR1,     // mask bit and 7-bit length code
    PH_EXTLEN,   // 2 or 8 extended length bytes
    PH_KEY,      // 4 mask key bytes
    PH_PAYLOAD   // payload bytes
  } wsd_phase_t;

  // One result item
  typedef struct packed {
    wsd_event_t  event_kind;
    logic        has_byte;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic        message_end;
  } wsd_result_t;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
// WebSocket frame deframer, receive side: one byte per item in, zero or one result out.
// Output: a result is registered and on the out_ port the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; ready drops only while the result register is full
// and not being taken.
// Reset: synchronous active-low rst_n; parser returns to expecting a first header byte.
// Depends on wsd_pkg, wsd_parser, wsd_out_stage.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic       out_has_byte,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_end,
  output logic       out_message_end
);

  logic        acc;
  logic        res_vld;
  wsd_result_t res;
  wsd_result_t out_res;

  assign acc = in_valid && in_ready;

  // Header parse and unmask
  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .res_vld (res_vld),
    .res     (res)
  );

  // Result register
  wsd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res       (res),
    .slot_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_event_kind   = out_res.event_kind;
  assign out_has_byte     = out_res.has_byte;
  assign out_payload_byte = out_res.payload_byte;
  assign out_frame_end    = out_res.frame_end;
  assign out_message_end  = out_res.message_end;

endmodule

// File: hw/rtl/wsd_parser.sv
// Header parser and unmasker: holds the frame state and builds at most one
// result per accepted byte. Depends on wsd_pkg.
module wsd_parser import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  logic [7:0]  rx_byte,
  output logic        res_vld,
  output wsd_result_t res
);

  wsd_phase_t  phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic        len16_r, len16_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  kphase_r, kphase_nxt;

  logic        is_data;
  logic [63:0] rem_dec;
  logic [7:0]  key_byte;
  logic        last_pay;
  logic        ev_vld;
  wsd_result_t ev;

  assign is_data = (opcode_r <= OP_DATA_MAX);
  assign rem_dec = rem_r - 64'd1;
  assign last_pay = (rem_dec == 64'd0);

  // Key byte for this payload position, first key byte first
  always_comb begin
    unique case (kphase_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Frame end event without a payload byte
  always_comb begin
    ev = '0;
    ev_vld = 1'b1;
    ev.frame_end = 1'b1;
    if (is_data) begin
      ev.event_kind  = EV_DATA;
      ev.message_end = fin_r;
    end else if (opcode_r == OP_PING) begin
      ev.event_kind = EV_PING;
    end else if (opcode_r == OP_PONG) begin
      ev_vld = 1'b0;
    end else if (opcode_r == OP_CLOSE) begin
      ev.event_kind = EV_CLOSE;
    end else begin
      ev.event_kind = EV_BADOP;
    end
  end

  // Next state and result
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    masked_nxt = masked_r;
    len16_nxt  = len16_r;
    rem_nxt    = rem_r;
    key_nxt    = key_r;
    kphase_nxt = kphase_r;
    res_vld    = 1'b0;
    res        = '0;
    if (acc) begin
      unique case (phase_r)
        PH_HDR1: begin
          masked_nxt = rx_byte[7];
          len16_nxt  = (rx_byte[6:0] == LEN_EXT16);
          key_nxt    = '0;
          kphase_nxt = 2'd0;
          cnt_nxt    = 3'd0;
          if (rx_byte[6:0] < LEN_EXT16) begin
            rem_nxt = {57'd0, rx_byte[6:0]};
            if (rx_byte[7]) begin
              phase_nxt = PH_KEY;
            end else if (rx_byte[6:0] == 7'd0) begin
              phase_nxt = PH_HDR0;
              res_vld   = ev_vld;
              res       = ev;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            rem_nxt   = '0;
            phase_nxt = PH_EXTLEN;
          end
        end
        PH_EXTLEN: begin
          rem_nxt = {rem_r[55:0], rx_byte};
          cnt_nxt = cnt_r + 3'd1;
          if ((len16_r && cnt_r == 3'd1) || cnt_r == 3'd7) begin
            cnt_nxt    = 3'd0;
            kphase_nxt = 2'd0;
            if (masked_r) begin
              phase_nxt = PH_KEY;
            end else if (rem_nxt == 64'd0) begin
              phase_nxt = PH_HDR0;
              res_vld   = ev_vld;
              res       = ev;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], rx_byte};
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == 3'd3) begin
            cnt_nxt    = 3'd0;
            kphase_nxt = 2'd0;
            if (rem_r == 64'd0) begin
              phase_nxt = PH_HDR0;
              res_vld   = ev_vld;
              res       = ev;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          kphase_nxt = kphase_r + 2'd1;
          rem_nxt    = rem_dec;
          if (last_pay) phase_nxt = PH_HDR0;
          if (is_data || opcode_r == OP_PING) begin
            res_vld            = 1'b1;
            res.event_kind     = is_data ? EV_DATA : EV_PING;
            res.has_byte       = 1'b1;
            res.payload_byte   = rx_byte ^ key_byte;
            res.frame_end      = last_pay;
            res.message_end    = last_pay && is_data && fin_r;
          end else if (last_pay) begin
            res_vld = ev_vld;
            res     = ev;
          end
        end
        default: begin
          // first header byte; RSV bits ignored
          fin_nxt    = rx_byte[7];
          opcode_nxt = rx_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Frame header fields, length and key
  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    opcode_r <= opcode_nxt;
    masked_r <= masked_nxt;
    len16_r  <= len16_nxt;
    rem_r    <= rem_nxt;
    key_r    <= key_nxt;
    kphase_r <= kphase_nxt;
  end

  // A payload phase always has bytes left to come
  a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (rem_r != 64'd0))
    else $error("payload phase with zero remaining length");

  a_res_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> acc)
    else $error("result produced without an accepted item");

  a_msg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.message_end) |-> (res.frame_end && res.event_kind == EV_DATA))
    else $error("message end outside the end of a data frame");

  a_byte_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.has_byte) |-> (res.event_kind == EV_DATA || res.event_kind == EV_PING))
    else $error("payload byte on close or error event");

endmodule

// File: hw/rtl/wsd_out_stage.sv
// Result register: holds one result item for the output channel and gives
// the input side its ready. Depends on wsd_pkg.
module wsd_out_stage import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_vld,
  input  wsd_result_t res,
  output logic        slot_free,
  output logic        out_valid,
  input  logic        out_ready,
  output wsd_result_t out_res
);

  logic        vld_r;
  wsd_result_t res_r;

  // Free when empty or being drained this cycle
  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_vld) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) res_r <= res;
  end

  // A new item only lands in a slot that is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> slot_free)
    else $error("result register overwritten while full");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_ready && !res_vld) |=> !vld_r)
    else $error("result register not emptied after being taken");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |=> vld_r)
    else $error("result register not filled");

endmodule
